>>> hdl/lrs_pkg.sv
// ============================================================================
// lrs_pkg
// Shared widths, operation codes and defaults for the latency statistics block.
// ============================================================================
`default_nettype none

package lrs_pkg;

    // Field and accumulator widths
    localparam int LAT_W = 16;
    localparam int OP_W  = 2;
    localparam int TSUM_W = 48;
    localparam int TCNT_W = 32;

    // Default depth of the moving-average window
    localparam int WINDOW_DEF = 10;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } lrs_state_t;

endpackage

`default_nettype wire

>>> hdl/latency_running_stats.sv
// ============================================================================
// latency_running_stats
// Running latest / moving average / overall mean / max / min over latency
// samples, gated by start and stop events.
// ============================================================================
// A start transaction gives no result. A stop transaction clears the totals,
// maximum and minimum and gives an all-zero result through the handoff
// state. A counted sample goes through these steps from accept to result:
// read the oldest window entry and update the accumulators, load the
// dividers, run shift-and-subtract division (one quotient bit per cycle,
// the window and overall means side by side), and hand the result to the
// output register once it is free. Input is stalled until that handoff.
// The block works on one transaction at a time; a finished result waits in
// the output register while the next transaction is accepted. The window
// ring is not cleared by stop and holds undefined data until written.
// ============================================================================
`default_nettype none

module latency_running_stats
    import lrs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [LAT_W-1:0]   latency,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [LAT_W-1:0]        latest,
    output logic [LAT_W-1:0]        window_average,
    output logic [LAT_W-1:0]        overall_average,
    output logic [LAT_W-1:0]        maximum,
    output logic [LAT_W-1:0]        minimum
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RSUM_W = LAT_W + FILL_W;
    localparam int CNT_W  = $clog2(LAT_W);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(LAT_W - 1);

    // Control and statistics state
    lrs_state_t         state_reg, state_next;
    logic               active_reg, active_next;
    logic               stop_reg, stop_next;
    logic [LAT_W-1:0]   sample_reg, sample_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [RSUM_W-1:0]  rsum_reg, rsum_next;
    logic [TSUM_W-1:0]  tsum_reg, tsum_next;
    logic [TCNT_W-1:0]  tcnt_reg, tcnt_next;
    logic [LAT_W-1:0]   max_reg, max_next;
    logic [LAT_W-1:0]   min_reg, min_next;

    // Divider shift registers
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FILL_W-1:0]  wrem_reg, wrem_next;
    logic [LAT_W-1:0]   wquo_reg, wquo_next;
    logic [TCNT_W-1:0]  orem_reg, orem_next;
    logic [LAT_W-1:0]   oquo_reg, oquo_next;
    logic               osat_reg, osat_next;

    // Output register
    logic               ovalid_reg, ovalid_next;
    logic [LAT_W-1:0]   olatest_reg, olatest_next;
    logic [LAT_W-1:0]   owavg_reg, owavg_next;
    logic [LAT_W-1:0]   ooavg_reg, ooavg_next;
    logic [LAT_W-1:0]   omax_reg, omax_next;
    logic [LAT_W-1:0]   omin_reg, omin_next;

    // Window ring memory
    logic [LAT_W-1:0]   ring_mem [WINDOW];
    logic [LAT_W-1:0]   ring_rd_reg;
    logic               ring_wr;

    logic               in_take;
    logic               out_free;
    logic               ring_full;
    logic [TSUM_W:0]    tsum_add;
    logic [FILL_W:0]    wtry;
    logic [FILL_W:0]    wdiff;
    logic [TCNT_W:0]    otry;
    logic [TCNT_W:0]    odiff;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !ovalid_reg || !out_stall;
    assign ring_full = (fill_reg == FILL_FULL);
    assign ring_wr  = (state_reg == ST_UPDATE);

    // Saturating accumulate and divider step
    assign tsum_add = {1'b0, tsum_reg} + {{(TSUM_W + 1 - LAT_W){1'b0}}, sample_reg};
    assign wtry  = {wrem_reg, wquo_reg[LAT_W-1]};
    assign wdiff = wtry - {1'b0, fill_reg};
    assign otry  = {orem_reg, oquo_reg[LAT_W-1]};
    assign odiff = otry - {1'b0, tcnt_reg};

    // Ring store: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        ring_rd_reg <= ring_mem[pos_reg];
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        stop_next    = stop_reg;
        sample_next  = sample_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        rsum_next    = rsum_reg;
        tsum_next    = tsum_reg;
        tcnt_next    = tcnt_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        cnt_next     = cnt_reg;
        wrem_next    = wrem_reg;
        wquo_next    = wquo_reg;
        orem_next    = orem_reg;
        oquo_next    = oquo_reg;
        osat_next    = osat_reg;
        ovalid_next  = ovalid_reg && out_stall;
        olatest_next = olatest_reg;
        owavg_next   = owavg_reg;
        ooavg_next   = ooavg_reg;
        omax_next    = omax_reg;
        omin_next    = omin_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    sample_next = latency;
                    if (operation == OP_START)
                    begin
                        active_next = 1'b1;
                    end
                    else if (operation == OP_STOP)
                    begin
                        active_next = 1'b0;
                        tsum_next   = '0;
                        tcnt_next   = '0;
                        max_next    = '0;
                        min_next    = '0;
                        stop_next   = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else if (operation == OP_SAMPLE && active_reg)
                    begin
                        stop_next  = 1'b0;
                        state_next = ST_UPDATE;
                    end
                end
            end

            // Window, totals and extremes take the new sample
            ST_UPDATE:
            begin
                if (ring_full)
                begin
                    rsum_next = rsum_reg - {{FILL_W{1'b0}}, ring_rd_reg}
                              + {{FILL_W{1'b0}}, sample_reg};
                end
                else
                begin
                    rsum_next = rsum_reg + {{FILL_W{1'b0}}, sample_reg};
                    fill_next = fill_reg + 1'b1;
                end
                pos_next  = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                tsum_next = tsum_add[TSUM_W] ? {TSUM_W{1'b1}} : tsum_add[TSUM_W-1:0];
                if (tcnt_reg != {TCNT_W{1'b1}})
                begin
                    tcnt_next = tcnt_reg + 1'b1;
                end
                if (sample_reg > max_reg || max_reg == '0)
                begin
                    max_next = sample_reg;
                end
                if (sample_reg < min_reg || min_reg == '0)
                begin
                    min_next = sample_reg;
                end
                state_next = ST_LOAD;
            end

            // High parts seed the remainders, low parts shift in bit by bit
            ST_LOAD:
            begin
                wrem_next  = rsum_reg[RSUM_W-1:LAT_W];
                wquo_next  = rsum_reg[LAT_W-1:0];
                orem_next  = tsum_reg[TSUM_W-1:LAT_W];
                oquo_next  = tsum_reg[LAT_W-1:0];
                osat_next  = (tsum_reg[TSUM_W-1:LAT_W] >= tcnt_reg);
                cnt_next   = DIV_LAST;
                state_next = ST_DIV;
            end

            // One restoring step per cycle on both dividers
            ST_DIV:
            begin
                if (!wdiff[FILL_W])
                begin
                    wrem_next = wdiff[FILL_W-1:0];
                end
                else
                begin
                    wrem_next = wtry[FILL_W-1:0];
                end
                wquo_next = {wquo_reg[LAT_W-2:0], !wdiff[FILL_W]};
                if (!odiff[TCNT_W])
                begin
                    orem_next = odiff[TCNT_W-1:0];
                end
                else
                begin
                    orem_next = otry[TCNT_W-1:0];
                end
                oquo_next = {oquo_reg[LAT_W-2:0], !odiff[TCNT_W]};
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // Hand the result over once the output register is free
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    olatest_next = stop_reg ? '0 : sample_reg;
                    owavg_next   = stop_reg ? '0 : wquo_reg;
                    ooavg_next   = stop_reg ? '0 : (osat_reg ? {LAT_W{1'b1}} : oquo_reg);
                    omax_next    = max_reg;
                    omin_next    = min_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            fill_reg   <= '0;
            pos_reg    <= '0;
            rsum_reg   <= '0;
            tsum_reg   <= '0;
            tcnt_reg   <= '0;
            max_reg    <= '0;
            min_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            rsum_reg   <= rsum_next;
            tsum_reg   <= tsum_next;
            tcnt_reg   <= tcnt_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        stop_reg    <= stop_next;
        sample_reg  <= sample_next;
        wrem_reg    <= wrem_next;
        wquo_reg    <= wquo_next;
        orem_reg    <= orem_next;
        oquo_reg    <= oquo_next;
        osat_reg    <= osat_next;
        olatest_reg <= olatest_next;
        owavg_reg   <= owavg_next;
        ooavg_reg   <= ooavg_next;
        omax_reg    <= omax_next;
        omin_reg    <= omin_next;
    end

    assign out_valid       = ovalid_reg;
    assign latest          = olatest_reg;
    assign window_average  = owavg_reg;
    assign overall_average = ooavg_reg;
    assign maximum         = omax_reg;
    assign minimum         = omin_reg;

    // Window bookkeeping stays in range
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill beyond depth");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("ring position beyond depth");

    // Min never above max; an unset max implies an unset min
    a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= max_reg)
        else $error("max/min trackers out of step");

    // Window remainder stays below the divisor during division
    a_wrem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (wrem_reg < fill_reg))
        else $error("window divider remainder not reduced");

    // A new result is only loaded from the handoff state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside handoff");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for latency_running_stats. A directed table covers the
// extremes, every operation and the corner cases; randomized start / sample /
// stop sessions follow. Each result is checked against the table's expected values or a local predictor.
// ============================================================================

module tb;

    import lrs_pkg::*;

    localparam int WIN        = WINDOW_DEF;
    localparam int CNT_W      = $clog2(WIN + 1);
    localparam int ACC_W      = LAT_W + CNT_W;
    localparam int HALF_CLK   = 4;
    localparam int RESET_CYC  = 11;
    localparam int ITEM_GOAL  = 1100;
    localparam int HOLD_CYC   = 400;
    localparam int DRAIN_CYC  = 40;
    localparam int IDLE_LIMIT = 4000;

    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [TSUM_W-1:0] SUM_MAX   = '1;
    localparam logic [TCNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [LAT_W-1:0] latest;
        logic [LAT_W-1:0] win_avg;
        logic [LAT_W-1:0] all_avg;
        logic [LAT_W-1:0] hi;
        logic [LAT_W-1:0] lo;
    } stats_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [LAT_W-1:0] lat;
        bit               typed;
        stats_t           want;
    } dir_row_t;

    localparam stats_t ZERO_STATS = '0;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  operation = OP_SAMPLE;
    logic [LAT_W-1:0] latency = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [LAT_W-1:0] latest;
    logic [LAT_W-1:0] window_average;
    logic [LAT_W-1:0] overall_average;
    logic [LAT_W-1:0] maximum;
    logic [LAT_W-1:0] minimum;

    // Predictor state
    bit               stats_on;
    logic [LAT_W-1:0] ring_mem [WIN];
    logic [CNT_W-1:0] ring_cnt;
    logic [CNT_W-1:0] ring_ptr;
    logic [ACC_W-1:0] ring_acc;
    logic [TSUM_W-1:0] run_sum;
    logic [TCNT_W-1:0] run_cnt;
    logic [LAT_W-1:0] hi_seen;
    logic [LAT_W-1:0] lo_seen;

    stats_t   stats_due [$];
    dir_row_t dir_rows [$];

    int  mismatches;
    int  n_items;
    int  n_results;
    int  n_sessions;
    int  idle_cycles;
    bit  calm;
    bit  hold_req;

    latency_running_stats dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .latency         (latency),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .latest          (latest),
        .window_average  (window_average),
        .overall_average (overall_average),
        .maximum         (maximum),
        .minimum         (minimum)
    );

    always #HALF_CLK clk = ~clk;

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Latency: extremes, realistic small values and full range
    function automatic logic [LAT_W-1:0] rand_latency();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 6)
            return LAT_W'($urandom_range(0, 200));
        else
            return LAT_W'($urandom);
    endfunction

    // Running statistics update for one transaction
    task automatic advance_stats(input logic [OP_W-1:0] op, input logic [LAT_W-1:0] lat,
                                 output bit emits, output bit counted, output stats_t res);
        logic [TSUM_W-1:0] mean;
        logic [ACC_W-1:0]  win_q;
        begin
            emits   = 1'b0;
            counted = 1'b1;
            res     = '0;
            case (op)
                OP_START: stats_on = 1'b1;
                OP_STOP:
                begin
                    stats_on = 1'b0;
                    run_sum  = '0;
                    run_cnt  = '0;
                    hi_seen  = '0;
                    lo_seen  = '0;
                    emits    = 1'b1;
                end
                OP_SAMPLE:
                begin
                    if (!stats_on)
                        counted = 1'b0;
                    else
                    begin
                        // saturating totals
                        if (run_sum > SUM_MAX - TSUM_W'(lat))
                            run_sum = SUM_MAX;
                        else
                            run_sum = run_sum + TSUM_W'(lat);
                        if (run_cnt != COUNT_MAX)
                            run_cnt = run_cnt + 1'b1;
                        // window ring: drop the oldest entry once full
                        if (ring_cnt >= CNT_W'(WIN))
                            ring_acc = ring_acc - ACC_W'(ring_mem[ring_ptr]);
                        else
                            ring_cnt = ring_cnt + 1'b1;
                        ring_acc = ring_acc + ACC_W'(lat);
                        ring_mem[ring_ptr] = lat;
                        ring_ptr = (ring_ptr == CNT_W'(WIN - 1)) ? '0 : ring_ptr + 1'b1;
                        win_q = ring_acc / ACC_W'(ring_cnt);
                        mean  = run_sum / TSUM_W'(run_cnt);
                        if (mean > TSUM_W'(16'hFFFF))
                            mean = TSUM_W'(16'hFFFF);
                        // zero means unset: a zero sample re-arms the minimum
                        if (lat > hi_seen || hi_seen == '0)
                            hi_seen = lat;
                        if (lat < lo_seen || lo_seen == '0)
                            lo_seen = lat;
                        res.latest  = lat;
                        res.win_avg = win_q[LAT_W-1:0];
                        res.all_avg = mean[LAT_W-1:0];
                        res.hi      = hi_seen;
                        res.lo      = lo_seen;
                        emits       = 1'b1;
                    end
                end
                default: counted = 1'b0;
            endcase
        end
    endtask

    // Offer one transaction, hold it until accepted, then record what it causes
    task automatic send_item(input logic [OP_W-1:0] op, input logic [LAT_W-1:0] lat,
                             input bit typed, input stats_t want);
        bit     emits;
        bit     counted;
        stats_t res;
        int     gap;
        begin
            in_valid  <= 1'b1;
            operation <= op;
            latency   <= lat;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            advance_stats(op, lat, emits, counted, res);
            if (emits)
                stats_due.push_back(typed ? want : res);
            if (counted)
                n_items++;
            gap = calm ? 0 : pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [LAT_W-1:0] want,
                               input logic [LAT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            mismatches++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        stats_t exp_q;
        if (rst_n && out_valid && !out_stall)
        begin
            if (stats_due.size() == 0)
            begin
                $error("result with no transaction pending");
                mismatches++;
            end
            else
            begin
                exp_q = stats_due.pop_front();
                n_results++;
                check_field("latest", exp_q.latest, latest);
                check_field("window_average", exp_q.win_avg, window_average);
                check_field("overall_average", exp_q.all_avg, overall_average);
                check_field("maximum", exp_q.hi, maximum);
                check_field("minimum", exp_q.lo, minimum);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stalls, with an occasional long hold-off
    initial
    begin
        bit stall_v;
        int dur;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                stall_v = ($urandom_range(0, 2) == 0);
                dur     = stall_v ? 1 + pick_gap() : $urandom_range(1, 8);
                out_stall <= stall_v;
                repeat (dur) @(posedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        int n_samples;
        int n_noise;
        logic [OP_W-1:0] noise_op;

        stats_on  = 1'b0;
        ring_cnt  = '0;
        ring_ptr  = '0;
        ring_acc  = '0;
        run_sum   = '0;
        run_cnt   = '0;
        hi_seen   = '0;
        lo_seen   = '0;
        mismatches = 0;
        n_items   = 0;
        n_results = 0;
        n_sessions = 0;
        idle_cycles = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;

        // Directed table
        dir_rows.push_back('{OP_SAMPLE, 16'd123, 1'b0, ZERO_STATS});  // ignored, inactive
        dir_rows.push_back('{OP_STOP, 16'd0, 1'b1, ZERO_STATS});      // stop while inactive
        dir_rows.push_back('{OP_UNUSED, 16'hFFFF, 1'b0, ZERO_STATS}); // unused code
        dir_rows.push_back('{OP_START, 16'hFFFF, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_START, 16'd0, 1'b0, ZERO_STATS});     // start while active
        dir_rows.push_back('{OP_SAMPLE, 16'hFFFF, 1'b1,
                             '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}});
        dir_rows.push_back('{OP_SAMPLE, 16'd0, 1'b1,
                             '{16'd0, 16'd32767, 16'd32767, 16'hFFFF, 16'd0}});
        dir_rows.push_back('{OP_SAMPLE, 16'd1, 1'b0, ZERO_STATS});    // minimum re-armed
        dir_rows.push_back('{OP_UNUSED, 16'd500, 1'b0, ZERO_STATS});  // unused while active
        dir_rows.push_back('{OP_SAMPLE, 16'd40000, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd2, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'hFFFE, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'h8000, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd7, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd1000, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd0, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'hFFFF, 1'b0, ZERO_STATS}); // window wraps
        dir_rows.push_back('{OP_SAMPLE, 16'd12345, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd300, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_STOP, 16'hFFFF, 1'b1, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd999, 1'b0, ZERO_STATS});  // ignored after stop
        dir_rows.push_back('{OP_STOP, 16'd0, 1'b1, ZERO_STATS});
        dir_rows.push_back('{OP_START, 16'd0, 1'b0, ZERO_STATS});
        dir_rows.push_back('{OP_SAMPLE, 16'd50, 1'b0, ZERO_STATS});   // ring kept over stop
        dir_rows.push_back('{OP_SAMPLE, 16'hAAAA, 1'b0, ZERO_STATS});

        // Reset
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].lat, dir_rows[i].typed, dir_rows[i].want);

        // Random sessions: mostly start / samples / stop, some noise
        while (n_items < ITEM_GOAL)
        begin
            n_sessions++;
            calm = ($urandom_range(0, 4) == 0);
            if (n_sessions % 40 == 5)
            begin
                // keep offering while the receiver holds off
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                n_noise = $urandom_range(1, 3);
                repeat (n_noise)
                begin
                    noise_op = OP_W'($urandom_range(0, 3));
                    send_item(noise_op, LAT_W'($urandom), 1'b0, ZERO_STATS);
                end
            end
            send_item(OP_START, LAT_W'($urandom), 1'b0, ZERO_STATS);
            n_samples = (n_sessions % 15 == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 25);
            repeat (n_samples)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item($urandom_range(0, 1) ? OP_UNUSED : OP_START,
                              LAT_W'($urandom), 1'b0, ZERO_STATS);
                else
                    send_item(OP_SAMPLE, rand_latency(), 1'b0, ZERO_STATS);
            end
            if ($urandom_range(0, 9) != 0)
                send_item(OP_STOP, LAT_W'($urandom), 1'b0, ZERO_STATS);
            if (n_sessions % 25 == 12)
            begin
                // sender pauses until everything has drained
                in_valid <= 1'b0;
                while (stats_due.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d transactions over %0d random sessions with stalls and hold-offs;",
                 n_items, n_sessions);
        $display("%0d results compared, %0d mismatches.", n_results, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lrs_pkg.sv
hdl/latency_running_stats.sv
tb/tb.sv
